@@ src/sabv_pkg.sv @@
// ----------------------------------------------------------------------------
// sabv_pkg
// Shared widths, types and constants of the signed vector angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sabv_pkg;

   localparam int CoordWidth   = 24;
   localparam int AngleWidth   = 17;
   localparam int AngleFrac    = 8;
   localparam int ProdWidth    = 2 * CoordWidth;      // one coordinate product
   localparam int SumWidth     = ProdWidth + 2;       // sum of three products
   localparam int NormWidth    = SumWidth - 1;        // squared length, unsigned
   localparam int SqInWidth    = 66;                  // squared length << 16
   localparam int LenWidth     = SqInWidth / 2;       // square root of that
   localparam int DenWidth     = 2 * LenWidth;        // product of lengths
   localparam int MagWidth     = NormWidth + 16;      // |dot| << 16
   localparam int QWidth       = 31;                  // Q30 cosine, 0..2^30
   localparam int SinInWidth   = 62;                  // 2^60 - c^2
   localparam int SinWidth     = 31;
   localparam int CordSteps    = 20;
   localparam int CordWidth    = 34;                  // Q30 vector, signed
   localparam int ZWidth       = 34;                  // Q24 degrees, signed
   localparam int DegShift     = 24;

   localparam logic signed [ZWidth-1:0] Deg90  = ZWidth'(90) <<< DegShift;
   localparam logic signed [ZWidth-1:0] Deg180 = ZWidth'(180) <<< DegShift;

   // atan(2^-i) in degrees, Q24
   function automatic logic signed [ZWidth-1:0] atan_deg(input logic [4:0] idx);
      logic signed [ZWidth-1:0] val;
      case (idx)
         5'd0:  val = 34'sd754974720;
         5'd1:  val = 34'sd445687602;
         5'd2:  val = 34'sd235489088;
         5'd3:  val = 34'sd119537938;
         5'd4:  val = 34'sd60000934;
         5'd5:  val = 34'sd30029717;
         5'd6:  val = 34'sd15018523;
         5'd7:  val = 34'sd7509720;
         5'd8:  val = 34'sd3754917;
         5'd9:  val = 34'sd1877466;
         5'd10: val = 34'sd938734;
         5'd11: val = 34'sd469367;
         5'd12: val = 34'sd234683;
         5'd13: val = 34'sd117342;
         5'd14: val = 34'sd58671;
         5'd15: val = 34'sd29335;
         5'd16: val = 34'sd14668;
         5'd17: val = 34'sd7334;
         5'd18: val = 34'sd3667;
         5'd19: val = 34'sd1833;
         default: val = '0;
      endcase
      return val;
   endfunction

   typedef struct packed {
      logic signed [CoordWidth-1:0] first_x;
      logic signed [CoordWidth-1:0] first_y;
      logic signed [CoordWidth-1:0] first_z;
      logic signed [CoordWidth-1:0] second_x;
      logic signed [CoordWidth-1:0] second_y;
      logic signed [CoordWidth-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [AngleWidth-1:0] angle_degrees;
      logic                         degenerate;
   } rsp_type;

   // side information that rides along the pipeline
   typedef struct packed {
      logic degenerate;
      logic dot_neg;
      logic cross_neg;
   } side_type;

endpackage
`default_nettype wire

@@ src/sabv_if.sv @@
// ----------------------------------------------------------------------------
// sabv_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface sabv_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/sabv_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// sabv_sqrt_stage
// One registered step of a restoring integer square root: two result bits.
// ----------------------------------------------------------------------------
`default_nettype none
module sabv_sqrt_stage
   import sabv_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [5:0]                  first_pos,
   input  wire logic [SqInWidth-1:0]        rem_in,
   input  wire logic [LenWidth-1:0]         root_in,
   output logic      [SqInWidth-1:0]        rem_out,
   output logic      [LenWidth-1:0]         root_out
);
   localparam int Bits = 2;

   logic [SqInWidth-1:0] rem_c [Bits+1];
   logic [LenWidth-1:0]  root_c [Bits+1];

   // root digits are produced msb first; position of digit = first_pos - k
   always_comb begin
      rem_c[0]  = rem_in;
      root_c[0] = root_in;
      for (int k = 0; k < Bits; k++) begin
         logic [SqInWidth+1:0] trial;
         int pos;
         pos   = int'(first_pos) - k;
         trial = ({2'b00, (SqInWidth)'(root_c[k])} << (pos + 1))
                 + ((SqInWidth+2)'(1) << (2 * pos));
         if (pos >= 0 && (SqInWidth+2)'(rem_c[k]) >= trial) begin
            rem_c[k+1]  = SqInWidth'((SqInWidth+2)'(rem_c[k]) - trial);
            root_c[k+1] = root_c[k] | (LenWidth'(1) << pos);
         end else begin
            rem_c[k+1]  = rem_c[k];
            root_c[k+1] = root_c[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_out  <= rem_c[Bits];
         root_out <= root_c[Bits];
      end
   end
endmodule
`default_nettype wire

@@ src/signed_angle_between_vectors_top.sv @@
// ----------------------------------------------------------------------------
// signed_angle_between_vectors_top
// Signed angle in degrees between two 3-D fixed-point vectors.
// ----------------------------------------------------------------------------
// A fixed-depth pipeline of 90 register stages that takes one item per cycle
// while the output is not held (products, sums, two
// square roots of 17 steps, two length-product stages, a 30-step division,
// the cosine stage, a 16-step sine root, the CORDIC set-up, 20 CORDIC steps
// and the output register, each a register stage). The whole pipeline
// advances together; when the result side stalls it holds, so ready drops
// only while the output is held.
`default_nettype none
module signed_angle_between_vectors_top
   import sabv_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   sabv_if.sink     req,
   sabv_if.source   rsp
);
   localparam int SqSteps  = LenWidth / 2 + 1;   // 17 stages, two bits each
   localparam int DivSteps = 30;
   localparam int SinSteps = SinWidth / 2 + 1;   // 16 stages
   localparam int Depth    = 2 + SqSteps + 2 + DivSteps + 1 + SinSteps + 1
                             + CordSteps + 1;

   logic advance;
   logic [Depth-1:0] valid_ff;
   assign advance   = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = valid_ff[Depth-1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Depth-2:0], req.valid};
      end
   end

   // stage 1: products
   logic signed [ProdWidth-1:0] p_ff [11];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0]  <= req.data.first_x * req.data.second_x;
         p_ff[1]  <= req.data.first_y * req.data.second_y;
         p_ff[2]  <= req.data.first_z * req.data.second_z;
         p_ff[3]  <= req.data.first_z * req.data.second_x;
         p_ff[4]  <= req.data.first_x * req.data.second_z;
         p_ff[5]  <= req.data.first_x * req.data.first_x;
         p_ff[6]  <= req.data.first_y * req.data.first_y;
         p_ff[7]  <= req.data.first_z * req.data.first_z;
         p_ff[8]  <= req.data.second_x * req.data.second_x;
         p_ff[9]  <= req.data.second_y * req.data.second_y;
         p_ff[10] <= req.data.second_z * req.data.second_z;
      end
   end

   // stage 2: sums
   logic signed [SumWidth-1:0] dot_ff;
   logic [NormWidth-1:0]       na_ff, nb_ff;
   side_type                   side2_ff;
   always_ff @(posedge clock) begin
      logic signed [SumWidth-1:0] dot_v, cr_v;
      if (advance) begin
         dot_v = SumWidth'(p_ff[0]) + SumWidth'(p_ff[1]) + SumWidth'(p_ff[2]);
         cr_v  = SumWidth'(p_ff[3]) - SumWidth'(p_ff[4]);
         na_ff <= NormWidth'(SumWidth'(p_ff[5]) + SumWidth'(p_ff[6]) + SumWidth'(p_ff[7]));
         nb_ff <= NormWidth'(SumWidth'(p_ff[8]) + SumWidth'(p_ff[9]) + SumWidth'(p_ff[10]));
         dot_ff <= dot_v;
         side2_ff.degenerate <= 1'b0;
         side2_ff.dot_neg    <= dot_v < 0;
         side2_ff.cross_neg  <= cr_v < 0;
      end
   end

   // square roots of both squared lengths, two bits per stage
   logic [SqInWidth-1:0] ra [SqSteps+1];
   logic [SqInWidth-1:0] rb [SqSteps+1];
   logic [LenWidth-1:0]  qa [SqSteps+1];
   logic [LenWidth-1:0]  qb [SqSteps+1];
   logic [MagWidth-1:0]  mag_d [SqSteps+1];
   side_type             side_d [SqSteps+1];
   assign ra[0]  = SqInWidth'({na_ff, 16'b0});
   assign rb[0]  = SqInWidth'({nb_ff, 16'b0});
   assign qa[0]  = '0;
   assign qb[0]  = '0;
   assign mag_d[0] = {NormWidth'(dot_ff < 0 ? -dot_ff : dot_ff), 16'b0};
   always_comb begin
      side_d[0] = side2_ff;
      side_d[0].degenerate = (na_ff == '0) || (nb_ff == '0);
   end

   for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
      sabv_sqrt_stage u_sqa (
         .clock(clock), .enable(advance), .first_pos(6'(LenWidth - 1 - 2 * g)),
         .rem_in(ra[g]), .root_in(qa[g]), .rem_out(ra[g+1]), .root_out(qa[g+1]));
      sabv_sqrt_stage u_sqb (
         .clock(clock), .enable(advance), .first_pos(6'(LenWidth - 1 - 2 * g)),
         .rem_in(rb[g]), .root_in(qb[g]), .rem_out(rb[g+1]), .root_out(qb[g+1]));
      always_ff @(posedge clock) begin
         if (advance) begin
            mag_d[g+1]  <= mag_d[g];
            side_d[g+1] <= side_d[g];
         end
      end
   end

   // length product, split in two partial products over two stages
   logic [DenWidth-1:0] plo_ff, phi_ff, den_ff;
   logic [MagWidth-1:0] mag_m1_ff, mag_m2_ff;
   side_type            side_m1_ff, side_m2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         plo_ff     <= DenWidth'(qa[SqSteps]) * DenWidth'(qb[SqSteps][16:0]);
         phi_ff     <= DenWidth'(qa[SqSteps]) * DenWidth'(qb[SqSteps][LenWidth-1:17]);
         mag_m1_ff  <= mag_d[SqSteps];
         side_m1_ff <= side_d[SqSteps];
         den_ff     <= plo_ff + (phi_ff << 17);
         mag_m2_ff  <= mag_m1_ff;
         side_m2_ff <= side_m1_ff;
      end
   end

   // restoring division, one quotient bit per stage
   localparam int RemW = DenWidth + 1;
   logic [RemW-1:0]     dr [DivSteps+1];
   logic [RemW-1:0]     dd [DivSteps+1];
   logic [QWidth-1:0]   dq [DivSteps+1];
   logic                dsat [DivSteps+1];
   side_type            dside [DivSteps+1];
   assign dr[0]    = RemW'(mag_m2_ff);
   assign dd[0]    = RemW'(den_ff);
   assign dq[0]    = '0;
   assign dsat[0]  = RemW'(mag_m2_ff) >= RemW'(den_ff);
   assign dside[0] = side_m2_ff;

   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      always_ff @(posedge clock) begin
         logic [RemW-1:0] two_r;
         if (advance) begin
            two_r = dr[g] << 1;
            if (two_r >= dd[g]) begin
               dr[g+1] <= two_r - dd[g];
               dq[g+1] <= {dq[g][QWidth-2:0], 1'b1};
            end else begin
               dr[g+1] <= two_r;
               dq[g+1] <= {dq[g][QWidth-2:0], 1'b0};
            end
            dd[g+1]    <= dd[g];
            dsat[g+1]  <= dsat[g];
            dside[g+1] <= dside[g];
         end
      end
   end

   // cosine magnitude and 2^60 - c^2
   logic [QWidth-1:0]    c_ff;
   logic [SinInWidth:0]  s2_ff;
   side_type             side_c_ff;
   always_ff @(posedge clock) begin
      logic [QWidth-1:0] cv;
      if (advance) begin
         cv = dsat[DivSteps] ? QWidth'(1) << 30 : dq[DivSteps];
         c_ff  <= cv;
         s2_ff <= (SinInWidth+1)'((64'd1 << 60) - 64'(cv) * 64'(cv));
         side_c_ff <= dside[DivSteps];
      end
   end

   // sine root
   logic [SqInWidth-1:0]  sr [SinSteps+1];
   logic [LenWidth-1:0]   sq [SinSteps+1];
   logic [QWidth-1:0]     sc [SinSteps+1];
   side_type              sside [SinSteps+1];
   assign sr[0]    = SqInWidth'(s2_ff);
   assign sq[0]    = '0;
   assign sc[0]    = c_ff;
   assign sside[0] = side_c_ff;
   for (genvar g = 0; g < SinSteps; g++) begin : g_sin
      sabv_sqrt_stage u_sqs (
         .clock(clock), .enable(advance), .first_pos(6'(SinWidth - 2 * g)),
         .rem_in(sr[g]), .root_in(sq[g]), .rem_out(sr[g+1]), .root_out(sq[g+1]));
      always_ff @(posedge clock) begin
         if (advance) begin
            sc[g+1]    <= sc[g];
            sside[g+1] <= sside[g];
         end
      end
   end

   // CORDIC set-up
   logic signed [CordWidth-1:0] cx [CordSteps+1];
   logic signed [CordWidth-1:0] cy [CordSteps+1];
   logic signed [ZWidth-1:0]    cz [CordSteps+1];
   side_type                    cside [CordSteps+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         if (sside[SinSteps].dot_neg && sc[SinSteps] != '0) begin
            cx[0] <= CordWidth'(sq[SinSteps]);
            cy[0] <= CordWidth'(sc[SinSteps]);
            cz[0] <= Deg90;
         end else begin
            cx[0] <= CordWidth'(sc[SinSteps]);
            cy[0] <= CordWidth'(sq[SinSteps]);
            cz[0] <= '0;
         end
         cside[0] <= sside[SinSteps];
      end
   end

   for (genvar g = 0; g < CordSteps; g++) begin : g_cord
      always_ff @(posedge clock) begin
         if (advance) begin
            if (cy[g] > 0) begin
               cx[g+1] <= cx[g] + (cy[g] >>> g);
               cy[g+1] <= cy[g] - (cx[g] >>> g);
               cz[g+1] <= cz[g] + atan_deg(5'(g));
            end else begin
               cx[g+1] <= cx[g] - (cy[g] >>> g);
               cy[g+1] <= cy[g] + (cx[g] >>> g);
               cz[g+1] <= cz[g] - atan_deg(5'(g));
            end
            cside[g+1] <= cside[g];
         end
      end
   end

   // clamp, round, sign
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      logic signed [ZWidth-1:0] zc, zr;
      logic signed [AngleWidth-1:0] a;
      if (advance) begin
         zc = cz[CordSteps];
         if (zc < 0) zc = '0;
         if (zc > Deg180) zc = Deg180;
         zr = (zc + (ZWidth'(1) <<< (DegShift - AngleFrac - 1))) >>> (DegShift - AngleFrac);
         a  = AngleWidth'(zr);
         if (cside[CordSteps].degenerate) begin
            out_ff.angle_degrees <= '0;
            out_ff.degenerate    <= 1'b1;
         end else begin
            out_ff.angle_degrees <= cside[CordSteps].cross_neg ? -a : a;
            out_ff.degenerate    <= 1'b0;
         end
      end
   end
   assign rsp.data = out_ff;
endmodule
`default_nettype wire

@@ tb/signed_angle_between_vectors_top_test.sv @@
// ----------------------------------------------------------------------------
// signed_angle_between_vectors_top_test
// Self-checking bench for the signed angle between two 3-D vectors.
// ----------------------------------------------------------------------------
// A table of directed vector pairs runs first: zero vectors, parallel and
// antiparallel pairs, axis cases with positive, negative and zero cross y,
// and full-scale coordinates. Random pairs follow, drawn from full-range, small,
// near-parallel and zero vectors. A bit-true angle model predicts every
// result. Sender and receiver idle at random in the first two of three phases,
// and in the last the receiver once holds off long enough to back the pipeline up.
`default_nettype none
module signed_angle_between_vectors_top_test;
   import sabv_pkg::*;

   localparam int  ClockHalf   = 6;
   localparam int  ResetCycles = 10;
   localparam int  RandItems   = 400;
   localparam int  DrainCycles = 300;
   localparam int  HoldCycles  = 400;
   localparam int  CycleLimit  = 400000;
   localparam logic signed [CoordWidth-1:0] CoordMax = 24'sh7FFFFF;
   localparam logic signed [CoordWidth-1:0] CoordMin = 24'sh800000;

   // atan(2^-i) in degrees, Q24
   localparam longint AtanQ24 [CordSteps] = '{
      754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466,
      938734, 469367, 234683, 117342, 58671,
      29335, 14668, 7334, 3667, 1833
   };

   typedef struct packed {
      req_type item;
      logic    typed;     // expected value given in the row
      rsp_type want;
   } row_type;

   logic clock;
   logic reset;

   sabv_if #(.payload_type(req_type)) req_chan (clock);
   sabv_if #(.payload_type(rsp_type)) rsp_chan (clock);

   signed_angle_between_vectors_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   rsp_type angle_queue [$];
   int      mismatch_count = 0;
   int      sent_count = 0;
   int      got_count = 0;
   int      degen_count = 0;
   int      cycle_count = 0;
   int      tx_idle_pct = 0;
   int      rx_idle_pct = 0;
   logic    long_hold = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // ------------------------------------------------------------------
   // angle model
   // ------------------------------------------------------------------
   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // floor(num * 2^30 / den), saturated to 2^30
   function automatic longint cosine_q30(input longint unsigned num,
                                         input longint unsigned den);
      longint unsigned r;
      longint q;
      r = num;
      q = 0;
      if (r >= den) return longint'(1) << 30;
      for (int i = 0; i < 30; i++) begin
         q = q << 1;
         if (r >= den - r) begin
            r = r - (den - r);
            q = q | 1;
         end else begin
            r = r + r;
         end
      end
      return q;
   endfunction

   function automatic rsp_type predict_angle(input req_type p);
      longint ax, ay, az, bx, by, bz;
      longint dot, cross_y, c, s, x, y, z, xs, ys, ang;
      longint unsigned na, nb, la, lb, mag;
      rsp_type r;
      ax = p.first_x;  ay = p.first_y;  az = p.first_z;
      bx = p.second_x; by = p.second_y; bz = p.second_z;
      dot     = ax * bx + ay * by + az * bz;
      cross_y = az * bx - ax * bz;
      na = ax * ax + ay * ay + az * az;
      nb = bx * bx + by * by + bz * bz;
      r  = '0;
      if (na == 0 || nb == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      la  = root64(na << 16);
      lb  = root64(nb << 16);
      mag = longint'(dot < 0 ? -dot : dot) << 16;
      c   = cosine_q30(mag, la * lb);
      s   = root64((64'd1 << 60) - c * c);
      if (dot < 0) c = -c;
      // negative cosine: start from the vector turned by -90 degrees
      if (c < 0) begin
         x = s; y = -c; z = longint'(90) << DegShift;
      end else begin
         x = c; y = s; z = 0;
      end
      for (int i = 0; i < CordSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + AtanQ24[i];
         end else begin
            x = x - ys; y = y + xs; z = z - AtanQ24[i];
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(180) << DegShift)) z = longint'(180) << DegShift;
      ang = (z + (longint'(1) << (DegShift - AngleFrac - 1))) >>> (DegShift - AngleFrac);
      if (cross_y < 0) ang = -ang;
      r.angle_degrees = ang[AngleWidth-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic row_type make_row(input int ax, ay, az, bx, by, bz,
                                        input logic typed, input int angle,
                                        input logic degen);
      row_type row;
      row.item.first_x  = ax[CoordWidth-1:0];
      row.item.first_y  = ay[CoordWidth-1:0];
      row.item.first_z  = az[CoordWidth-1:0];
      row.item.second_x = bx[CoordWidth-1:0];
      row.item.second_y = by[CoordWidth-1:0];
      row.item.second_z = bz[CoordWidth-1:0];
      row.typed = typed;
      row.want.angle_degrees = angle[AngleWidth-1:0];
      row.want.degenerate    = degen;
      return row;
   endfunction

   function automatic logic signed [CoordWidth-1:0] rand_coord(input int mode);
      case (mode)
         0: return CoordWidth'($urandom);                      // full range
         1: return CoordWidth'($signed($urandom_range(8191)) - 4096);
         default: return CoordWidth'($signed($urandom_range(15)) - 8);
      endcase
   endfunction

   function automatic req_type rand_pair();
      req_type p;
      int sel, k, mode;
      sel  = $urandom_range(99);
      mode = $urandom_range(2);
      p.first_x  = rand_coord(mode);
      p.first_y  = rand_coord(mode);
      p.first_z  = rand_coord(mode);
      p.second_x = rand_coord(mode);
      p.second_y = rand_coord(mode);
      p.second_z = rand_coord(mode);
      if (sel < 20) begin
         // scaled copy, pointing either way, with a slight nudge
         k = $signed($urandom_range(6)) - 3;
         if (k == 0) k = 1;
         p.first_x  = rand_coord(1);
         p.first_y  = rand_coord(1);
         p.first_z  = rand_coord(1);
         p.second_x = CoordWidth'(k * p.first_x + ($signed($urandom_range(2)) - 1));
         p.second_y = CoordWidth'(k * p.first_y);
         p.second_z = CoordWidth'(k * p.first_z);
      end else if (sel < 25) begin
         p.first_x = '0; p.first_y = '0; p.first_z = '0;
      end else if (sel < 30) begin
         p.second_x = '0; p.second_y = '0; p.second_z = '0;
      end else if (sel < 35) begin
         // vectors in the x-y plane or along y: cross y of zero
         p.first_z = '0; p.second_z = '0;
         if (sel < 33) begin
            p.first_x = '0; p.second_x = '0;
         end
      end
      return p;
   endfunction

   // offer one item, possibly after an idle gap; keep valid high otherwise
   task automatic send_item(input req_type p);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= p;
      do @(posedge clock); while (!req_chan.ready);
      angle_queue.push_back(predict_angle(p));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at result %0d: got %0d, want %0d", what, got_count, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // receiver: random ready, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // result check against the oldest expected angle
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (angle_queue.size() == 0) begin
            report_mismatch("unexpected result", $signed(rsp_chan.data.angle_degrees), 0);
         end else begin
            want = angle_queue.pop_front();
            if (rsp_chan.data.angle_degrees !== want.angle_degrees)
               report_mismatch("angle_degrees", $signed(rsp_chan.data.angle_degrees),
                               $signed(want.angle_degrees));
            if (rsp_chan.data.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_chan.data.degenerate, want.degenerate);
            if (want.degenerate) degen_count++;
         end
         got_count++;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, angle_queue.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      row_type rows [18];
      rsp_type want;
      int      wait_count;
      int      phase_tx [3];
      int      phase_rx [3];
      phase_tx = '{29, 83, 0};
      phase_rx = '{83, 29, 0};

      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // degenerate rows are typed in; the rest go through the model
      rows[0]  = make_row(0, 0, 0, 0, 0, 0, 1, 0, 1);
      rows[1]  = make_row(0, 0, 0, 4096, 0, 0, 1, 0, 1);
      rows[2]  = make_row(-4096, 7, 3, 0, 0, 0, 1, 0, 1);
      rows[3]  = make_row(4096, 0, 0, 4096, 0, 0, 0, 0, 0);
      rows[4]  = make_row(4096, 0, 0, -4096, 0, 0, 0, 0, 0);
      rows[5]  = make_row(4096, 0, 0, 0, 0, 4096, 0, 0, 0);
      rows[6]  = make_row(0, 0, 4096, 4096, 0, 0, 0, 0, 0);
      rows[7]  = make_row(0, 4096, 0, 4096, 0, 0, 0, 0, 0);
      rows[8]  = make_row(0, 4096, 0, 0, -4096, 0, 0, 0, 0);
      rows[9]  = make_row(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                          0, 0, 0);
      rows[10] = make_row(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
                          0, 0, 0);
      rows[11] = make_row(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                          0, 0, 0);
      rows[12] = make_row(CoordMin, 0, CoordMax, CoordMax, 0, CoordMin, 0, 0, 0);
      rows[13] = make_row(1, 0, 0, 0, 0, 1, 0, 0, 0);
      rows[14] = make_row(1, 0, 0, -1, 0, -1, 0, 0, 0);
      rows[15] = make_row(-1, -1, -1, 1, 1, 1, 0, 0, 0);
      rows[16] = make_row(1000, 0, 1, -1000, 0, 0, 0, 0, 0);
      rows[17] = make_row(CoordMax, 1, CoordMin, 1, CoordMax, 1, 0, 0, 0);

      foreach (rows[i]) begin
         if (rows[i].typed) begin
            want = predict_angle(rows[i].item);
            if (want !== rows[i].want) begin
               $display("directed row %0d: model disagrees with typed value", i);
               mismatch_count++;
            end
         end
         send_item(rows[i].item);
      end

      // random phases with shifting idle patterns
      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = phase_tx[ph];
         rx_idle_pct = phase_rx[ph];
         if (ph == 2) long_hold = 1'b1;
         for (int n = 0; n < RandItems / 3; n++) send_item(rand_pair());
      end
      req_chan.valid <= 1'b0;

      // drain
      while (angle_queue.size() != 0) @(posedge clock);
      wait_count = 0;
      while (wait_count < DrainCycles) begin
         @(posedge clock);
         wait_count++;
      end
      if (angle_queue.size() != 0) begin
         $display("%0d expected results never arrived", angle_queue.size());
         mismatch_count++;
      end

      $display("ran %0d vector pairs (%0d directed), %0d results back, %0d degenerate",
               sent_count, 18, got_count, degen_count);
      $display("idle phases 29/83, 83/29 and none, plus one long output hold; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
